FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for clocked concurrent checks, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TTCG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTCG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ttcg_pkg.sv
// ----------------------------------------------------------------------------
// ttcg_pkg
// shared types and constants of the text terminal cell grid
// ----------------------------------------------------------------------------
package ttcg_pkg;

	// field widths
	localparam int KIND_W      = 2;
	localparam int CHAR_W      = 8;
	localparam int RROW_W      = 6;
	localparam int RCOL_W      = 7;
	localparam int OROW_W      = 6;
	localparam int OCOL_W      = 7;
	localparam int CUR_COL_W   = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int COLS_REG_W  = 8;
	localparam int ROWS_REG_W  = 7;

	// stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 48;

	// compare width, covers field values and area sizes up to 256
	localparam int CMP_W = 9;

	// default grid limits and register reset values
	localparam int DEF_MAX_COLUMNS = 128;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int COLS_RESET      = 80;
	localparam int ROWS_RESET      = 25;

	// characters
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;

	// request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_PUT       = 2'd0,
		KIND_BACKSPACE = 2'd1,
		KIND_READ      = 2'd2,
		KIND_NONE      = 2'd3
	} kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_BLANK,
		ST_WRITE,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	// memory operation for the store
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_from_ram;
	} mem_op_t;

	// sequencer status
	typedef struct packed {
		logic idle;
		logic done;
	} seq_status_t;

	// one result
	typedef struct packed {
		logic                 cell_written;
		logic [OROW_W-1:0]    write_row;
		logic [OCOL_W-1:0]    write_column;
		logic [CHAR_W-1:0]    written_char;
		logic                 scrolled;
		logic [OROW_W-1:0]    cursor_row_now;
		logic [CUR_COL_W-1:0] cursor_column_now;
		logic [CHAR_W-1:0]    read_char;
	} result_t;

endpackage

FILE: hw/rtl/ttcg_store.sv
// ----------------------------------------------------------------------------
// ttcg_store
// cell memory with a registered read port and a one-stage write port
// ----------------------------------------------------------------------------
module ttcg_store #(
	parameter int ADDR_W = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ttcg_pkg::mem_op_t               op,
	input  logic [ADDR_W-1:0]               rd_addr,
	input  logic [ADDR_W-1:0]               wr_addr,
	input  logic [ttcg_pkg::CHAR_W-1:0]     wr_char,
	output logic [ttcg_pkg::CHAR_W-1:0]     rd_data
);
	import ttcg_pkg::*;

	localparam int DEPTH = 1 << ADDR_W;

	logic [CHAR_W-1:0] mem [DEPTH];
	logic [CHAR_W-1:0] rd_data_q;
	logic              wr_en_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic [CHAR_W-1:0] wr_char_s1;
	logic              from_ram_s1;
	logic [CHAR_W-1:0] wr_data;

	// write stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= op.wr_en;
		end
	end

	// write stage payload
	always_ff @(posedge clk) begin
		wr_addr_s1  <= wr_addr;
		wr_char_s1  <= wr_char;
		from_ram_s1 <= op.wr_from_ram;
	end

	// copy takes the cell read in the cycle before
	assign wr_data = from_ram_s1 ? rd_data_q : wr_char_s1;

	// memory ports
	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			mem[wr_addr_s1] <= wr_data;
		end
		if (op.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/ttcg_seq.sv
// ----------------------------------------------------------------------------
// ttcg_seq
// sequencer: cursor, area registers, clear and scroll sweeps, request steps
// ----------------------------------------------------------------------------
module ttcg_seq #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64,
	parameter int ADDR_W      = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	input  ttcg_pkg::kind_t                   item_kind,
	input  logic [ttcg_pkg::CHAR_W-1:0]       item_char,
	input  logic [ttcg_pkg::RROW_W-1:0]       item_row,
	input  logic [ttcg_pkg::RCOL_W-1:0]       item_col,
	input  logic                              cfg_valid,
	input  logic [ttcg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ttcg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              out_free,
	output ttcg_pkg::seq_status_t             status,
	output ttcg_pkg::result_t                 result,
	output ttcg_pkg::mem_op_t                 mem_op,
	output logic [ADDR_W-1:0]                 rd_addr,
	output logic [ADDR_W-1:0]                 wr_addr,
	output logic [ttcg_pkg::CHAR_W-1:0]       wr_char,
	input  logic [ttcg_pkg::CHAR_W-1:0]       rd_data
);
	import ttcg_pkg::*;

	localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CCW = $clog2(MAX_COLUMNS + 1);
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int COLS_INIT = (MAX_COLUMNS < COLS_RESET) ? MAX_COLUMNS : COLS_RESET;
	localparam int ROWS_INIT = (MAX_ROWS < ROWS_RESET) ? MAX_ROWS : ROWS_RESET;

	state_t            state_q, state_d;
	logic [RW-1:0]     cur_row_q;
	logic [CCW-1:0]    cur_col_q;
	logic [CCW-1:0]    cols_q;
	logic [RCW-1:0]    rows_q;
	logic [RW-1:0]     sr_q;
	logic [CW-1:0]     sc_q;
	logic [ADDR_W-1:0] clr_q;
	kind_t             kind_q;
	logic [CHAR_W-1:0] char_q;
	logic [RROW_W-1:0] rrow_q;
	logic [RCOL_W-1:0] rcol_q;
	logic              put_q;
	logic              res_written_q;
	logic [OROW_W-1:0] res_wrow_q;
	logic [OCOL_W-1:0] res_wcol_q;
	logic [CHAR_W-1:0] res_wchar_q;
	logic              res_scrolled_q;
	logic [CHAR_W-1:0] res_rchar_q;

	logic              newline_in;
	logic              wrap;
	logic [RCW-1:0]    row_next;
	logic              need_scroll;
	logic              in_area;
	logic              col_last;
	logic              row_last;
	logic              clr_last;
	logic [CHAR_W-1:0] wchar;
	logic [CCW-1:0]    cfg_cols;
	logic [RCW-1:0]    cfg_rows;
	logic [CCW-1:0]    fit_cols;
	logic [RCW-1:0]    fit_rows;
	logic              cfg_hit;

	// request decode terms
	assign newline_in  = (item_char == CHAR_NEWLINE);
	assign wrap        = (cur_col_q >= cols_q);
	assign row_next    = RCW'(cur_row_q) + RCW'(1);
	assign need_scroll = (row_next >= rows_q);
	assign in_area     = (CMP_W'(item_row) < CMP_W'(rows_q))
		&& (CMP_W'(item_col) < CMP_W'(cols_q));
	assign col_last    = (CCW'(sc_q) == cols_q - CCW'(1));
	assign row_last    = (RCW'(sr_q) == rows_q - RCW'(1));
	assign clr_last    = &clr_q;
	assign wchar       = (kind_q == KIND_PUT) ? char_q : CHAR_SPACE;

	// register writes, zero counts as one and large values saturate; rows use only cfg_data[6:0]
	always_comb begin
		if (cfg_data == '0) begin
			cfg_cols = CCW'(1);
		end else if (CMP_W'(cfg_data) > CMP_W'(MAX_COLUMNS)) begin
			cfg_cols = CCW'(MAX_COLUMNS);
		end else begin
			cfg_cols = CCW'(cfg_data);
		end
		if (cfg_data[ROWS_REG_W-1:0] == '0) begin
			cfg_rows = RCW'(1);
		end else if (CMP_W'(cfg_data[ROWS_REG_W-1:0]) > CMP_W'(MAX_ROWS)) begin
			cfg_rows = RCW'(MAX_ROWS);
		end else begin
			cfg_rows = RCW'(cfg_data[ROWS_REG_W-1:0]);
		end
		cfg_hit  = cfg_valid && ((cfg_index == CFG_COLUMNS) || (cfg_index == CFG_ROWS));
		fit_cols = (cfg_index == CFG_COLUMNS) ? cfg_cols : cols_q;
		fit_rows = (cfg_index == CFG_ROWS) ? cfg_rows : rows_q;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory operations
	always_comb begin
		state_d            = state_q;
		mem_op             = '0;
		status             = '0;
		rd_addr            = {RW'(rrow_q), CW'(rcol_q)};
		wr_addr            = '0;
		wr_char            = CHAR_SPACE;
		unique case (state_q)
			ST_CLEAR: begin
				mem_op.wr_en = 1'b1;
				wr_addr      = clr_q;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				status.idle = 1'b1;
				if (item_valid) begin
					unique case (item_kind)
						KIND_PUT: begin
							if ((newline_in || wrap) && need_scroll) begin
								state_d = (rows_q == RCW'(1)) ? ST_BLANK : ST_COPY;
							end else if (newline_in) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_WRITE;
							end
						end
						KIND_BACKSPACE: begin
							state_d = (cur_col_q != '0) ? ST_WRITE : ST_DONE;
						end
						KIND_READ: begin
							state_d = in_area ? ST_READ : ST_DONE;
						end
						KIND_NONE: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_COPY: begin
				mem_op.rd_en       = 1'b1;
				mem_op.wr_en       = 1'b1;
				mem_op.wr_from_ram = 1'b1;
				rd_addr            = {sr_q, sc_q};
				wr_addr            = {RW'(sr_q - RW'(1)), sc_q};
				if (col_last && row_last) begin
					state_d = ST_BLANK;
				end
			end
			ST_BLANK: begin
				mem_op.wr_en = 1'b1;
				wr_addr      = {sr_q, sc_q};
				if (col_last) begin
					state_d = put_q ? ST_WRITE : ST_DONE;
				end
			end
			ST_WRITE: begin
				mem_op.wr_en = 1'b1;
				wr_addr      = {cur_row_q, CW'(cur_col_q)};
				wr_char      = wchar;
				state_d      = ST_DONE;
			end
			ST_READ: begin
				mem_op.rd_en = 1'b1;
				state_d      = ST_READ_WAIT;
			end
			ST_READ_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				status.done = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// cursor, area, sweep counters and result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q      <= '0;
			cur_col_q      <= '0;
			cols_q         <= CCW'(COLS_INIT);
			rows_q         <= RCW'(ROWS_INIT);
			sr_q           <= '0;
			sc_q           <= '0;
			clr_q          <= '0;
			kind_q         <= KIND_NONE;
			char_q         <= '0;
			rrow_q         <= '0;
			rcol_q         <= '0;
			put_q          <= 1'b0;
			res_written_q  <= 1'b0;
			res_wrow_q     <= '0;
			res_wcol_q     <= '0;
			res_wchar_q    <= '0;
			res_scrolled_q <= 1'b0;
			res_rchar_q    <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
				end
				ST_IDLE: begin
					if (item_valid) begin
						kind_q         <= item_kind;
						char_q         <= item_char;
						rrow_q         <= item_row;
						rcol_q         <= item_col;
						put_q          <= !newline_in;
						res_written_q  <= 1'b0;
						res_wrow_q     <= '0;
						res_wcol_q     <= '0;
						res_wchar_q    <= '0;
						res_scrolled_q <= 1'b0;
						res_rchar_q    <= '0;
						case (item_kind)
							KIND_PUT: begin
								if (newline_in || wrap) begin
									cur_col_q <= '0;
									if (need_scroll) begin
										res_scrolled_q <= 1'b1;
										cur_row_q      <= RW'(rows_q - RCW'(1));
										sr_q           <= (rows_q == RCW'(1)) ? '0 : RW'(1);
										sc_q           <= '0;
									end else begin
										cur_row_q <= RW'(row_next);
									end
								end
							end
							KIND_BACKSPACE: begin
								if (cur_col_q != '0) begin
									cur_col_q <= cur_col_q - CCW'(1);
								end
							end
							KIND_READ: begin
								if (!in_area) begin
									res_rchar_q <= CHAR_SPACE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_COPY: begin
					if (col_last) begin
						sc_q <= '0;
						if (!row_last) begin
							sr_q <= sr_q + RW'(1);
						end
					end else begin
						sc_q <= sc_q + CW'(1);
					end
				end
				ST_BLANK: begin
					sc_q <= sc_q + CW'(1);
				end
				ST_WRITE: begin
					res_written_q <= 1'b1;
					res_wrow_q    <= OROW_W'(cur_row_q);
					res_wcol_q    <= OCOL_W'(cur_col_q);
					res_wchar_q   <= wchar;
					if (kind_q == KIND_PUT) begin
						cur_col_q <= cur_col_q + CCW'(1);
					end
				end
				ST_READ_WAIT: begin
					res_rchar_q <= rd_data;
				end
				default: begin
				end
			endcase

			// register write, cursor pulled back into the area
			if (cfg_hit) begin
				cols_q <= fit_cols;
				rows_q <= fit_rows;
				if (RCW'(cur_row_q) >= fit_rows) begin
					cur_row_q <= RW'(fit_rows - RCW'(1));
				end
				if (cur_col_q > fit_cols) begin
					cur_col_q <= fit_cols;
				end
			end
		end
	end

	// result fields
	always_comb begin
		result.cell_written      = res_written_q;
		result.write_row         = res_wrow_q;
		result.write_column      = res_wcol_q;
		result.written_char      = res_wchar_q;
		result.scrolled          = res_scrolled_q;
		result.cursor_row_now    = OROW_W'(cur_row_q);
		result.cursor_column_now = CUR_COL_W'(cur_col_q);
		result.read_char         = res_rchar_q;
	end

endmodule

FILE: hw/rtl/text_terminal_cell_grid.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_grid
// character cell grid with a cursor, backspace, cell reads and scroll-up
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: kind in s_tuser, character and read
// position in s_tdata. Each request gives exactly one result on the m_
// stream. The cfg_ channel writes the column count (index 0) and the row
// count (index 1); it is always ready and must only be used while idle.
// The steps of a request: a bare newline or an unused kind goes from
// idle straight to done, a character or backspace write passes a write
// state, and a cell read passes a read and a read wait state. A request
// that scrolls first copies (rows-1)*columns cells one row up and then
// blanks the bottom row, all through the single memory write port.
// s_tready is high only in the idle state, so at most one is in flight.
// After reset the store is swept to spaces, one cell per cycle over all
// 2**(row bits + column bits) cells (8192 at default size); s_tready
// stays low for that time, while cfg writes are taken.
// A finished result sits in the output register until m_tready; the next
// request is accepted meanwhile but its result waits for the slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_terminal_cell_grid #(
	parameter int MAX_COLUMNS = ttcg_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = ttcg_pkg::DEF_MAX_ROWS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] character, [13:8] read_row, [20:14] read_column
	input  logic [ttcg_pkg::S_TDATA_W-1:0]    s_tdata,
	// [1:0] kind
	input  logic [ttcg_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] cell_written, [6:1] write_row, [13:7] write_column,
	// [21:14] written_char, [22] scrolled, [28:23] cursor_row_now,
	// [36:29] cursor_column_now, [44:37] read_char
	output logic [ttcg_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ttcg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ttcg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ttcg_pkg::*;

	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ADDR_W = COL_W + ROW_W;

	seq_status_t       status;
	result_t           result;
	result_t           out_q;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;
	mem_op_t           mem_op;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [CHAR_W-1:0] wr_char;
	logic [CHAR_W-1:0] rd_data;

	// request handshake
	assign s_tready  = status.idle;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	ttcg_seq #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS),
		.ADDR_W      (ADDR_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (accept),
		.item_kind  (kind_t'(s_tuser[KIND_W-1:0])),
		.item_char  (s_tdata[7:0]),
		.item_row   (s_tdata[13:8]),
		.item_col   (s_tdata[20:14]),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_free   (out_free),
		.status     (status),
		.result     (result),
		.mem_op     (mem_op),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_char    (wr_char),
		.rd_data    (rd_data)
	);

	ttcg_store #(
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (mem_op),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_char (wr_char),
		.rd_data (rd_data)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (status.done) begin
			out_q <= result;
		end
	end

	// result packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.read_char, out_q.cursor_column_now,
		out_q.cursor_row_now, out_q.scrolled, out_q.written_char,
		out_q.write_column, out_q.write_row, out_q.cell_written};

	// checks
	`TTCG_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`TTCG_ASSERT_SAME(a_load_into_free, status.done, !m_tvalid || m_tready, "pending result lost")
	`TTCG_ASSERT_SAME(a_unwritten_zero, m_tvalid && !m_tdata[0], ~|m_tdata[21:1], "stray write")

endmodule

FILE: tb/sv/ttcg_grid_monitor.sv
// ----------------------------------------------------------------------------
// ttcg_grid_monitor
// watches the request, result and register channels of the cell grid,
// keeps its own copy of the grid and cursor, and checks every result
// ----------------------------------------------------------------------------
module ttcg_grid_monitor (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// [7:0] character, [13:8] read_row, [20:14] read_column
	input  logic [ttcg_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] kind
	input  logic [ttcg_pkg::S_TUSER_W-1:0]   s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] cell_written, [6:1] write_row, [13:7] write_column,
	// [21:14] written_char, [22] scrolled, [28:23] cursor_row_now,
	// [36:29] cursor_column_now, [44:37] read_char
	input  logic [ttcg_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [ttcg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ttcg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatch_count,
	output int                               results_owed
);
	import ttcg_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam int FIELD_COUNT  = 8;

	// shadow grid, cursor and registers
	logic [CHAR_W-1:0]     cell_grid [DEF_MAX_ROWS][DEF_MAX_COLUMNS];
	int                    cur_row;
	int                    cur_col;
	logic [COLS_REG_W-1:0] cols_reg;
	logic [ROWS_REG_W-1:0] rows_reg;
	result_t               awaited_results [$];

	// columns in use, zero counts as one, clipped to the grid
	function automatic int area_columns();
		if (cols_reg == '0) return 1;
		if (int'(cols_reg) > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
		return int'(cols_reg);
	endfunction

	function automatic int area_rows();
		if (rows_reg == '0) return 1;
		if (int'(rows_reg) > DEF_MAX_ROWS) return DEF_MAX_ROWS;
		return int'(rows_reg);
	endfunction

	// carriage return plus line feed, scrolls at the bottom row
	function automatic bit start_new_line();
		int rows;
		int cols;
		rows = area_rows();
		cols = area_columns();
		cur_col = 0;
		cur_row++;
		if (cur_row < rows) return 1'b0;
		// only the columns in use move, the rest keep their bytes
		for (int r = 1; r < rows; r++)
			for (int c = 0; c < cols; c++)
				cell_grid[r-1][c] = cell_grid[r][c];
		for (int c = 0; c < cols; c++)
			cell_grid[rows-1][c] = CHAR_SPACE;
		cur_row = rows - 1;
		return 1'b1;
	endfunction

	// apply one request to the shadow grid and build its result
	function automatic result_t terminal_step(kind_t kind, logic [CHAR_W-1:0] ch,
		logic [RROW_W-1:0] rr, logic [RCOL_W-1:0] rc);
		result_t res;
		res = '0;
		case (kind)
			KIND_PUT: begin
				if (ch == CHAR_NEWLINE || cur_col >= area_columns())
					res.scrolled = start_new_line();
				if (ch != CHAR_NEWLINE) begin
					cell_grid[cur_row][cur_col] = ch;
					res.cell_written = 1'b1;
					res.write_row    = OROW_W'(cur_row);
					res.write_column = OCOL_W'(cur_col);
					res.written_char = ch;
					cur_col++;
				end
			end
			KIND_BACKSPACE: begin
				if (cur_col > 0) begin
					cur_col--;
					cell_grid[cur_row][cur_col] = CHAR_SPACE;
					res.cell_written = 1'b1;
					res.write_row    = OROW_W'(cur_row);
					res.write_column = OCOL_W'(cur_col);
					res.written_char = CHAR_SPACE;
				end
			end
			KIND_READ: begin
				if (int'(rr) < area_rows() && int'(rc) < area_columns())
					res.read_char = cell_grid[rr][rc];
				else
					res.read_char = CHAR_SPACE;
			end
			default: begin
			end
		endcase
		res.cursor_row_now    = OROW_W'(cur_row);
		res.cursor_column_now = CUR_COL_W'(cur_col);
		return res;
	endfunction

	function automatic int field_value(result_t r, int idx);
		case (idx)
			0: return int'(r.cell_written);
			1: return int'(r.write_row);
			2: return int'(r.write_column);
			3: return int'(r.written_char);
			4: return int'(r.scrolled);
			5: return int'(r.cursor_row_now);
			6: return int'(r.cursor_column_now);
			default: return int'(r.read_char);
		endcase
	endfunction

	function automatic string field_name(int idx);
		case (idx)
			0: return "cell_written";
			1: return "write_row";
			2: return "write_column";
			3: return "written_char";
			4: return "scrolled";
			5: return "cursor_row_now";
			6: return "cursor_column_now";
			default: return "read_char";
		endcase
	endfunction

	// results are checked before a request of the same edge is predicted
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		bit      bad;
		if (!arst_n) begin
			foreach (cell_grid[r, c])
				cell_grid[r][c] = CHAR_SPACE;
			cur_row  = 0;
			cur_col  = 0;
			cols_reg = COLS_REG_W'(COLS_RESET);
			rows_reg = ROWS_REG_W'(ROWS_RESET);
			awaited_results.delete();
			mismatch_count = 0;
			results_owed   = 0;
		end else begin
			// compare a finished result with the oldest prediction
			if (m_tvalid && m_tready) begin
				got.cell_written      = m_tdata[0];
				got.write_row         = m_tdata[6:1];
				got.write_column      = m_tdata[13:7];
				got.written_char      = m_tdata[21:14];
				got.scrolled          = m_tdata[22];
				got.cursor_row_now    = m_tdata[28:23];
				got.cursor_column_now = m_tdata[36:29];
				got.read_char         = m_tdata[44:37];
				if (awaited_results.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("result %h arrived with no request outstanding", m_tdata);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					bad  = 1'b0;
					for (int f = 0; f < FIELD_COUNT; f++) begin
						if (field_value(got, f) != field_value(want, f)) begin
							if (mismatch_count < REPORT_LIMIT)
								$display("%s mismatch: expected %0d, actual %0d",
									field_name(f), field_value(want, f), field_value(got, f));
							bad = 1'b1;
						end
					end
					if (bad)
						mismatch_count++;
				end
			end
			// register writes, the cursor is pulled back into the area
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_COLUMNS: cols_reg = cfg_data;
					CFG_ROWS:    rows_reg = cfg_data[ROWS_REG_W-1:0];
					default: begin
					end
				endcase
				if (cfg_index == CFG_COLUMNS || cfg_index == CFG_ROWS) begin
					if (cur_row >= area_rows())
						cur_row = area_rows() - 1;
					if (cur_col > area_columns())
						cur_col = area_columns();
				end
			end
			// predict the accepted request
			if (s_tvalid && s_tready)
				awaited_results.push_back(terminal_step(kind_t'(s_tuser), s_tdata[7:0],
					s_tdata[13:8], s_tdata[20:14]));
			results_owed = awaited_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the text terminal cell grid: a directed opening over
// writes, wraps, backspaces, reads and scrolls, then random traffic over
// many grid sizes with random gaps on both streams; checking is done by
// the grid monitor beside the block
// ----------------------------------------------------------------------------
module tb_top;
	import ttcg_pkg::*;

	// register indexes the block ignores
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// [7:0] character, [13:8] read_row, [20:14] read_column
	logic [S_TDATA_W-1:0]   s_tdata;
	// [1:0] kind
	logic [S_TUSER_W-1:0]   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// [0] cell_written, [6:1] write_row, [13:7] write_column,
	// [21:14] written_char, [22] scrolled, [28:23] cursor_row_now,
	// [36:29] cursor_column_now, [44:37] read_char
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int mismatch_count;
	int results_owed;
	int area_cols;
	int area_rows;
	bit send_steady;
	bit take_steady;

	text_terminal_cell_grid dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ttcg_grid_monitor grid_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop, several times the slowest run with full-size scrolls
	initial begin
		#120000000;
		$display("text_terminal_cell_grid verification failed");
		$finish;
	end

	// one request, after a random gap
	task automatic send_request(input kind_t kind, input logic [CHAR_W-1:0] ch,
		input logic [RROW_W-1:0] rr, input logic [RCOL_W-1:0] rc);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, rc, rr, ch};
		@(posedge clk);
		while (!(s_tvalid && s_tready))
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and wait until every result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_owed != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready))
			@(posedge clk);
		@(negedge clk);
	endtask

	// resize the grid while idle, optionally poking an unused index too
	task automatic set_area(input int cols_data, input int rows_data, input bit spare);
		int rows_field;
		wait_drained();
		write_register(CFG_COLUMNS, CFG_DATA_W'(cols_data));
		write_register(CFG_ROWS, CFG_DATA_W'(rows_data));
		if (spare)
			write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
				CFG_DATA_W'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
		rows_field = rows_data % 128;
		area_cols = (cols_data == 0) ? 1 :
			(cols_data > DEF_MAX_COLUMNS ? DEF_MAX_COLUMNS : cols_data);
		area_rows = (rows_field == 0) ? 1 :
			(rows_field > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_field);
	endtask

	// mostly typing, with backspaces, reads and the odd unused kind
	task automatic random_requests(input int count, input int newline_pct);
		int                pick;
		logic [CHAR_W-1:0] ch;
		logic [RROW_W-1:0] rr;
		logic [RCOL_W-1:0] rc;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 29) == 0)
				send_steady = !send_steady;
			ch   = CHAR_W'($urandom_range(0, 255));
			rr   = RROW_W'($urandom_range(0, 63));
			rc   = RCOL_W'($urandom_range(0, 127));
			pick = $urandom_range(0, 99);
			if (pick < newline_pct) begin
				send_request(KIND_PUT, CHAR_NEWLINE, rr, rc);
			end else if (pick < 60) begin
				send_request(KIND_PUT, ch, rr, rc);
			end else if (pick < 73) begin
				send_request(KIND_BACKSPACE, ch, rr, rc);
			end else if (pick < 97) begin
				// most reads land inside the area
				if ($urandom_range(0, 3) != 0) begin
					rr = RROW_W'($urandom_range(0, area_rows - 1));
					rc = RCOL_W'($urandom_range(0, area_cols - 1));
				end
				send_request(KIND_READ, ch, rr, rc);
			end else begin
				send_request(KIND_NONE, ch, rr, rc);
			end
		end
	endtask

	// result side, random stalls with calm stretches
	initial begin : take_results
		int stall;
		m_tready    = 1'b0;
		take_steady = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 24) == 0)
				take_steady = !take_steady;
			stall = take_steady ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				m_tready <= 1'b0;
				@(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready))
				@(posedge clk);
			@(negedge clk);
		end
	end

	// request side and verdict
	initial begin
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		send_steady = 1'b0;
		area_cols   = COLS_RESET;
		area_rows   = ROWS_RESET;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset size: writes, backspaces down to column 0 and past it, reads
		send_request(KIND_PUT, 8'h41, 6'd0, 7'd0);
		send_request(KIND_PUT, 8'h00, 6'd0, 7'd0);
		send_request(KIND_PUT, 8'hFF, 6'd63, 7'd127);
		send_request(KIND_READ, 8'h00, 6'd0, 7'd0);
		send_request(KIND_READ, 8'h00, 6'd0, 7'd2);
		send_request(KIND_BACKSPACE, 8'h00, 6'd0, 7'd0);
		send_request(KIND_BACKSPACE, 8'h00, 6'd0, 7'd0);
		send_request(KIND_BACKSPACE, 8'h00, 6'd0, 7'd0);
		send_request(KIND_BACKSPACE, 8'hFF, 6'd0, 7'd0);
		send_request(KIND_PUT, CHAR_NEWLINE, 6'd0, 7'd0);
		send_request(KIND_READ, 8'h00, 6'd63, 7'd127);
		send_request(KIND_READ, 8'h00, 6'd24, 7'd79);
		send_request(KIND_NONE, 8'hFF, 6'd63, 7'd127);

		// tiny grid: end-of-line backspace, wrap with scroll, newline scroll
		set_area(3, 2, 1'b0);
		send_request(KIND_PUT, 8'h78, 6'd0, 7'd0);
		send_request(KIND_PUT, 8'h79, 6'd0, 7'd0);
		send_request(KIND_PUT, 8'h7A, 6'd0, 7'd0);
		send_request(KIND_BACKSPACE, 8'h00, 6'd0, 7'd0);
		send_request(KIND_PUT, 8'h7A, 6'd0, 7'd0);
		send_request(KIND_PUT, 8'h77, 6'd0, 7'd0);
		send_request(KIND_PUT, CHAR_NEWLINE, 6'd0, 7'd0);
		send_request(KIND_READ, 8'h00, 6'd0, 7'd0);
		send_request(KIND_READ, 8'h00, 6'd0, 7'd3);
		send_request(KIND_READ, 8'h00, 6'd1, 7'd2);

		// random traffic over sizes, extremes and out-of-range values among them
		set_area(1, 1, 1'b0);
		random_requests(80, 10);
		set_area(0, 0, 1'b1);
		random_requests(40, 10);
		set_area(7, 4, 1'b0);
		random_requests(150, 8);
		set_area(128, 64, 1'b0);
		random_requests(40, 2);
		set_area(16, 8, 1'b1);
		random_requests(150, 8);
		set_area(255, 8'h83, 1'b0);
		random_requests(60, 10);
		set_area(200, 127, 1'b0);
		random_requests(30, 2);
		set_area(5, 2, 1'b0);
		random_requests(100, 8);
		set_area(3, 64, 1'b1);
		random_requests(150, 20);
		set_area(40, 12, 1'b0);
		random_requests(150, 6);
		repeat (4) begin
			set_area($urandom_range(1, 24), $urandom_range(1, 10), 1'($urandom_range(0, 1)));
			random_requests(60, 8);
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("text_terminal_cell_grid verification clean");
		end else begin
			$display("text_terminal_cell_grid verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ttcg_pkg.sv
hw/rtl/ttcg_store.sv
hw/rtl/ttcg_seq.sv
hw/rtl/text_terminal_cell_grid.sv
tb/sv/ttcg_grid_monitor.sv
tb/sv/tb_top.sv
